FILE: src/dke_pkg.sv
// shared types, constants and helpers for the dirichlet kernel evaluator
package dke_pkg;

  localparam int INDEX_BITS_DEF      = 16;
  localparam int VALUE_FRAC_BITS_DEF = 16;
  localparam int IN_FIELD_W          = 16;
  localparam int ORDER_W             = 16;
  localparam int SPACING_W           = 32;
  localparam int X_FRAC_BITS         = 24;
  localparam int PHASE_W             = X_FRAC_BITS + 1;
  localparam int SINE_W              = 41;
  localparam int DEN_W               = SINE_W + ORDER_W;
  localparam int REC_SHIFT           = 39;
  localparam int REC_W               = 37;
  localparam int SERIES_STEPS        = 5;
  localparam int SINE_LAT            = 3 + 2 * SERIES_STEPS;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [33:0] PI_Q32  = 34'd13493037705;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic {
    CFG_KERNEL_ORDER = 1'b0,
    CFG_X_SPACING    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] phase_top;
    logic               whole;
    logic               whole_neg;
  } dke_item_t;

  typedef struct packed {
    logic whole;
    logic whole_neg;
    logic sign;
  } dke_side_t;

  function automatic int series_div(input int k);
    int d;
    case (k)
      0:       d = 110;
      1:       d = 72;
      2:       d = 42;
      3:       d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

endpackage

FILE: src/dke_front.sv
// front end: index request intake, phase forming and whole-point classification
module dke_front import dke_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_FIELD_W-1:0] in_tdata,
  input  logic [ORDER_W-1:0]    kernel_order,
  input  logic [SPACING_W-1:0]  x_spacing,
  input  logic                  q_full,
  output logic                  q_push,
  output dke_item_t             q_item
);

  localparam int IDX_USE = (INDEX_BITS < IN_FIELD_W) ? INDEX_BITS : IN_FIELD_W;

  logic                  s1_v_r, s2_v_r;
  logic                  s1_rdy, s2_rdy;
  logic [PHASE_W-1:0]    phase_r;
  logic [PHASE_W-1:0]    phase_nxt;
  logic [IN_FIELD_W-1:0] idx;
  logic [2*PHASE_W-1:0]  xprod;
  logic [PHASE_W+ORDER_W-1:0] tprod;
  dke_item_t             item_r, item_nxt;

  assign idx       = in_tdata & IN_FIELD_W'((1 << IDX_USE) - 1);
  assign xprod     = PHASE_W'(idx) * x_spacing[PHASE_W-1:0];
  assign phase_nxt = xprod[PHASE_W-1:0];

  assign tprod = kernel_order * phase_r;

  always_comb begin
    item_nxt.phase     = phase_r;
    item_nxt.phase_top = tprod[PHASE_W-1:0];
    item_nxt.whole     = (phase_r[X_FRAC_BITS-1:0] == '0);
    item_nxt.whole_neg = phase_r[X_FRAC_BITS] & ~kernel_order[0];
  end

  assign s2_rdy    = !s2_v_r || !q_full;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign q_push    = s2_v_r && !q_full;
  assign q_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_tvalid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) phase_r <= phase_nxt;
    if (s2_rdy) item_r  <= item_nxt;
  end

endmodule

FILE: src/dke_queue.sv
// short request queue between front and back
module dke_queue import dke_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dke_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output dke_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  dke_item_t        mem_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign full     = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

FILE: src/dke_sine.sv
// pipelined fixed-length sine of a half-turn phase
module dke_sine import dke_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [PHASE_W-1:0] phase_i,
  output logic [SINE_W-1:0]  mag_o,
  output logic               neg_o
);

  localparam int LAST = SINE_LAT - 1;

  logic [57:0]       y_r   [0:LAST-1];
  logic              neg_r [0:LAST];
  logic [31:0]       y2_r  [1:9];
  logic [30:0]       r_k   [0:SERIES_STEPS];
  logic [31:0]       v_k   [0:SERIES_STEPS-1];
  logic [SINE_W-1:0] mag_r;

  logic [23:0] q0, t0;
  logic [57:0] y0;
  logic [63:0] sq;
  logic [64:0] fin;

  assign q0 = phase_i[X_FRAC_BITS-1:0];
  assign t0 = (q0 <= 24'h80_0000) ? q0 : 24'(25'h100_0000 - {1'b0, q0});
  assign y0 = t0 * PI_Q32;
  assign sq = y_r[0][57:26] * y_r[0][57:26];
  assign fin = y_r[LAST-1][57:16] * r_k[SERIES_STEPS][30:8];

  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0]   <= y0;
      neg_r[0] <= phase_i[X_FRAC_BITS];
      y2_r[1]  <= sq[61:30];
      r_k[0]   <= Q30_ONE;
      mag_r    <= fin[62:22];
    end
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) neg_r[s] <= neg_r[s-1];
    end
  end

  for (genvar s = 1; s < LAST; s++) begin : g_y
    always_ff @(posedge clk) begin
      if (en) y_r[s] <= y_r[s-1];
    end
  end

  for (genvar s = 2; s <= 9; s++) begin : g_y2
    always_ff @(posedge clk) begin
      if (en) y2_r[s] <= y2_r[s-1];
    end
  end

  for (genvar k = 0; k < SERIES_STEPS; k++) begin : g_step
    localparam int          D = series_div(k);
    localparam logic [REC_W-1:0] M =
      REC_W'(((64'd1 << REC_SHIFT) + 64'(D) - 64'd1) / 64'(D));
    logic [62:0] prod;
    logic [68:0] quo;
    assign prod = y2_r[1+2*k] * r_k[k];
    assign quo  = v_k[k] * M;
    always_ff @(posedge clk) begin
      if (en) begin
        v_k[k]   <= prod[61:30];
        r_k[k+1] <= Q30_ONE - {1'b0, quo[68:REC_SHIFT]};
      end
    end
  end

  assign mag_o = mag_r;
  assign neg_o = neg_r[LAST];

endmodule

FILE: src/dke_div.sv
// pipelined restoring division, one quotient bit per stage, with saturation
module dke_div import dke_pkg::*; #(
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_i,
  input  logic [SINE_W-1:0]        num_i,
  input  logic [DEN_W-1:0]         den_i,
  input  dke_side_t                side_i,
  output logic                     v_o,
  output logic [VALUE_FRAC_BITS:0] mag_o,
  output dke_side_t                side_o
);

  localparam int VF    = VALUE_FRAC_BITS;
  localparam int REM_W = DEN_W + 1;

  logic             v_r    [0:VF];
  logic             sat_r  [0:VF];
  logic [REM_W-1:0] rem_r  [0:VF];
  logic [VF-1:0]    q_r    [0:VF];
  logic [DEN_W-1:0] den_r  [0:VF];
  dke_side_t        side_r [0:VF];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= v_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0]  <= (DEN_W'(num_i) >= den_i);
      rem_r[0]  <= REM_W'(num_i);
      q_r[0]    <= '0;
      den_r[0]  <= den_i;
      side_r[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= VF; s++) begin : g_bit
    logic [REM_W-1:0] rem2;
    logic             ge;
    assign rem2 = {rem_r[s-1][REM_W-2:0], 1'b0};
    assign ge   = (rem2 >= {1'b0, den_r[s-1]});
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[s]  <= sat_r[s-1];
        rem_r[s]  <= ge ? (rem2 - {1'b0, den_r[s-1]}) : rem2;
        q_r[s]    <= {q_r[s-1][VF-2:0], ge};
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign v_o    = v_r[VF];
  assign mag_o  = sat_r[VF] ? (VF+1)'(1) << VF : {1'b0, q_r[VF]};
  assign side_o = side_r[VF];

endmodule

FILE: src/dke_back.sv
// back end: two sine lanes, denominator scaling, division and result register
module dke_back import dke_pkg::*; #(
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ORDER_W-1:0]         kernel_order,
  input  logic                       q_empty,
  input  dke_item_t                  q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [VALUE_FRAC_BITS+1:0] kernel_value,
  output logic                       whole_point
);

  localparam int VF    = VALUE_FRAC_BITS;
  localparam int OUT_W = VF + 2;
  localparam int LAST  = SINE_LAT - 1;

  logic en;
  logic v_r [0:LAST];
  logic wh_r [0:LAST];
  logic wn_r [0:LAST];

  logic [SINE_W-1:0] top_mag, bot_mag;
  logic              top_neg, bot_neg;
  logic [DEN_W-1:0]  den_nxt;

  logic              a_v_r;
  logic [SINE_W-1:0] a_num_r;
  logic [DEN_W-1:0]  a_den_r;
  dke_side_t         a_side_r;

  logic              d_v;
  logic [VF:0]       d_mag;
  dke_side_t         d_side;

  logic              out_v_r;
  logic [OUT_W-1:0]  val_r, val_nxt;
  logic              wp_r;

  assign en    = !out_v_r || out_tready;
  assign q_pop = en && !q_empty;

  dke_sine u_top (
    .clk(clk), .en(en), .phase_i(q_item.phase_top), .mag_o(top_mag), .neg_o(top_neg)
  );
  dke_sine u_bot (
    .clk(clk), .en(en), .phase_i(q_item.phase), .mag_o(bot_mag), .neg_o(bot_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= !q_empty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wh_r[0] <= q_item.whole;
      wn_r[0] <= q_item.whole_neg;
    end
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        wh_r[s] <= wh_r[s-1];
        wn_r[s] <= wn_r[s-1];
      end
    end
  end

  assign den_nxt = kernel_order * bot_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= v_r[LAST];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num_r            <= top_mag;
      a_den_r            <= den_nxt;
      a_side_r.whole     <= wh_r[LAST];
      a_side_r.whole_neg <= wn_r[LAST];
      a_side_r.sign      <= top_neg ^ bot_neg;
    end
  end

  dke_div #(.VALUE_FRAC_BITS(VF)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(a_v_r), .num_i(a_num_r), .den_i(a_den_r),
    .side_i(a_side_r), .v_o(d_v), .mag_o(d_mag), .side_o(d_side)
  );

  always_comb begin
    if (d_side.whole) begin
      val_nxt = d_side.whole_neg ? -(OUT_W'(1) << VF) : (OUT_W'(1) << VF);
    end else if (d_side.sign && (d_mag != '0)) begin
      val_nxt = -OUT_W'(d_mag);
    end else begin
      val_nxt = OUT_W'(d_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= d_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      wp_r  <= d_side.whole;
    end
  end

  assign out_tvalid   = out_v_r;
  assign kernel_value = val_r;
  assign whole_point  = wp_r;

endmodule

FILE: src/dirichlet_kernel_eval_core.sv
// top level of the dirichlet kernel evaluator
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata[15:0] sample_index
//  out_    | out | out_tvalid/tready  | tdata kernel_value, tuser whole_point
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// one request per cycle sustained while out_tready is not held low; the result path runs
// through the 13-stage sine lanes and one division stage per result bit
// synchronous active-low reset empties the queue and all pipeline valids
// a stalled result holds the back end; the queue lets the front keep accepting until it fills
module dirichlet_kernel_eval_core import dke_pkg::*; #(
  parameter int INDEX_BITS      = INDEX_BITS_DEF,
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF,
  localparam int OUT_W          = VALUE_FRAC_BITS + 2,
  localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_FIELD_W-1:0]  in_tdata,   // sample_index
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // kernel_value, zero pad
  output logic                   out_tuser,  // whole_point
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [SPACING_W-1:0]   cfg_data
);

  logic [ORDER_W-1:0]   kernel_order_r;
  logic [SPACING_W-1:0] x_spacing_r;
  logic                 q_full, q_push, q_pop, q_empty;
  dke_item_t            push_item, pop_item;
  logic [OUT_W-1:0]     kernel_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_order_r <= ORDER_W'(1);
      x_spacing_r    <= SPACING_W'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KERNEL_ORDER: kernel_order_r <= cfg_data[ORDER_W-1:0];
        CFG_X_SPACING:    x_spacing_r    <= cfg_data;
        default:          ;
      endcase
    end
  end

  dke_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .kernel_order(kernel_order_r), .x_spacing(x_spacing_r),
    .q_full(q_full), .q_push(q_push), .q_item(push_item)
  );

  dke_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(push_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_item(pop_item)
  );

  dke_back #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .kernel_order(kernel_order_r), .q_empty(q_empty),
    .q_item(pop_item), .q_pop(q_pop), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .kernel_value(kernel_value), .whole_point(out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(kernel_value);

endmodule

FILE: src/dke_checker.sv
// port-level checks of the dirichlet kernel evaluator, bound to the top level
module dke_checker import dke_pkg::*; #(
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF,
  localparam int OUT_W          = VALUE_FRAC_BITS + 2,
  localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  logic signed [OUT_W-1:0] val;
  logic [OUT_W-1:0]        one_v, mone_v;

  assign val    = out_tdata[OUT_W-1:0];
  assign one_v  = OUT_W'(1) << VALUE_FRAC_BITS;
  assign mone_v = -one_v;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[OUT_W-1:0] == one_v) ||
                                (out_tdata[OUT_W-1:0] == mone_v))
    else $error("whole point result not plus or minus one");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (val <= $signed(one_v)) && (val >= $signed(mone_v)))
    else $error("result out of range");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >> OUT_W) == '0)
    else $error("padding bits not zero");

endmodule

bind dirichlet_kernel_eval_core dke_checker #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_dke_chk (
  .clk(clk), .rst_n(rst_n),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
